/* src/b5u_pkg.sv */
// Shared types and constants for the Big5 / UTF-16 table codec.
`timescale 1ns / 1ps

package b5u_pkg;

  localparam int unsigned BIG5_CODES_DEF = 32768;
  localparam int unsigned UNICODE_UNITS  = 65536;
  localparam int unsigned UNIT_W         = 16;
  localparam int unsigned REV_AW         = $clog2(UNICODE_UNITS);

  localparam logic [15:0] REV_INVALID = 16'hFFFF;
  localparam logic [15:0] SPACE_UNIT  = 16'h0020;
  localparam logic [15:0] ASCII_MAX   = 16'h007F;
  localparam logic [15:0] HI_SUR_MIN  = 16'hD800;
  localparam logic [15:0] HI_SUR_MAX  = 16'hDBFF;
  localparam logic [15:0] LO_SUR_MIN  = 16'hDC00;
  localparam logic [15:0] LO_SUR_MAX  = 16'hDFFF;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_DECODE = 2'd1,
    ACT_ENCODE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  // Leading part of an encode run, produced by a previously held high surrogate.
  typedef enum logic [1:0] {
    PA_NONE   = 2'd0,
    PA_SPACES = 2'd1,
    PA_LOOKUP = 2'd2
  } pair_kind_t;

  // Part of a run produced by the current byte or unit.
  typedef enum logic [2:0] {
    CK_NONE  = 3'd0,
    CK_LIT   = 3'd1,
    CK_SPACE = 3'd2,
    CK_REV   = 3'd3,
    CK_FWD   = 3'd4
  } cur_kind_t;

  typedef struct packed {
    pair_kind_t  pair;
    cur_kind_t   cur;
    logic [15:0] lit;
    logic        fwd_in_range;
  } run_desc_t;

  typedef struct packed {
    logic rd_en;
    logic fwd_we;
    logic rev_we;
  } tbl_ctl_t;

  typedef struct packed {
    logic [15:0] value;
    logic        valid;
  } result_t;

endpackage

/* src/b5u_tables.sv */
// Forward and reverse lookup memories with the post-reset clearing sweep.
`timescale 1ns / 1ps

module b5u_tables
  import b5u_pkg::*;
#(
  parameter int unsigned BIG5_CODES = BIG5_CODES_DEF,
  localparam int unsigned FWD_AW    = $clog2(BIG5_CODES)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tbl_ctl_t              ctl,
  input  logic [FWD_AW-1:0]     fwd_raddr,
  input  logic [FWD_AW-1:0]     fwd_waddr,
  input  logic [UNIT_W:0]       fwd_wdata,
  input  logic [REV_AW-1:0]     rev_raddr_a,
  input  logic [REV_AW-1:0]     rev_raddr_b,
  input  logic [REV_AW-1:0]     rev_waddr,
  input  logic [UNIT_W-1:0]     rev_wdata,
  output logic [UNIT_W:0]       fwd_rdata,
  output logic [UNIT_W-1:0]     rev_rdata_a,
  output logic [UNIT_W-1:0]     rev_rdata_b,
  output logic                  ready
);

  logic [UNIT_W:0]   fwd_mem [BIG5_CODES];
  logic [UNIT_W-1:0] rev_mem [UNICODE_UNITS];

  logic [UNIT_W:0]   fwd_rdata_r;
  logic [UNIT_W-1:0] rev_rdata_a_r;
  logic [UNIT_W-1:0] rev_rdata_b_r;

  logic              clr_busy_r, clr_busy_nxt;
  logic [REV_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              fwd_clr_en;

  assign fwd_clr_en = {1'b0, clr_cnt_r} < (REV_AW+1)'(BIG5_CODES);

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (&clr_cnt_r) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
    end
  end

  // The sweep owns the write ports until every entry holds its invalid value.
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      rev_mem[clr_cnt_r] <= REV_INVALID;
      if (fwd_clr_en) begin
        fwd_mem[clr_cnt_r[FWD_AW-1:0]] <= '0;
      end
    end else begin
      if (ctl.fwd_we) begin
        fwd_mem[fwd_waddr] <= fwd_wdata;
      end
      if (ctl.rev_we) begin
        rev_mem[rev_waddr] <= rev_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      fwd_rdata_r   <= fwd_mem[fwd_raddr];
      rev_rdata_a_r <= rev_mem[rev_raddr_a];
      rev_rdata_b_r <= rev_mem[rev_raddr_b];
    end
  end

  assign fwd_rdata   = fwd_rdata_r;
  assign rev_rdata_a = rev_rdata_a_r;
  assign rev_rdata_b = rev_rdata_b_r;
  assign ready       = !clr_busy_r;

endmodule

/* src/b5u_emit.sv */
// Result sequencer: expands one run descriptor into its items and drives the output register.
`timescale 1ns / 1ps

module b5u_emit
  import b5u_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  run_desc_t         desc,
  input  logic [UNIT_W:0]   fwd_rdata,
  input  logic [UNIT_W-1:0] rev_rdata_a,
  input  logic [UNIT_W-1:0] rev_rdata_b,
  output logic              can_take,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [15:0]       out_tdata,   // out_value
  output logic [0:0]        out_tuser,   // out_valid
  output logic              out_tlast
);

  run_desc_t   desc_r;
  logic        run_valid_r, run_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;

  logic        out_tvalid_r, out_tvalid_nxt;
  result_t     out_res_r;
  logic        out_last_r;

  result_t     a0, a1, c0, c1;
  result_t     slot [4];
  logic [1:0]  n_a, n_c;
  logic [2:0]  n_tot;
  logic        fwd_hit;
  logic        out_load, emit, is_last;

  // Turn a reverse entry into its two Big5 bytes, or two spaces on a miss.
  function automatic result_t rev_hi(input logic [15:0] code);
    result_t r;
    r.value = (code == REV_INVALID) ? SPACE_UNIT : {8'h00, code[15:8]};
    r.valid = (code != REV_INVALID);
    return r;
  endfunction

  function automatic result_t rev_lo(input logic [15:0] code);
    result_t r;
    r.value = (code == REV_INVALID) ? SPACE_UNIT : {8'h00, code[7:0]};
    r.valid = (code != REV_INVALID);
    return r;
  endfunction

  assign fwd_hit = desc_r.fwd_in_range && fwd_rdata[UNIT_W];

  always_comb begin
    a0  = '{value: SPACE_UNIT, valid: 1'b0};
    a1  = '{value: SPACE_UNIT, valid: 1'b0};
    n_a = 2'd0;
    case (desc_r.pair)
      PA_SPACES: n_a = 2'd2;
      PA_LOOKUP: begin
        n_a = 2'd2;
        a0  = rev_hi(rev_rdata_a);
        a1  = rev_lo(rev_rdata_a);
      end
      default: n_a = 2'd0;
    endcase

    c0  = '{value: SPACE_UNIT, valid: 1'b0};
    c1  = '{value: SPACE_UNIT, valid: 1'b0};
    n_c = 2'd0;
    case (desc_r.cur)
      CK_LIT: begin
        n_c = 2'd1;
        c0  = '{value: desc_r.lit, valid: 1'b1};
      end
      CK_SPACE: n_c = 2'd1;
      CK_REV: begin
        n_c = 2'd2;
        c0  = rev_hi(rev_rdata_b);
        c1  = rev_lo(rev_rdata_b);
      end
      CK_FWD: begin
        if (fwd_hit) begin
          n_c = 2'd1;
          c0  = '{value: fwd_rdata[UNIT_W-1:0], valid: 1'b1};
        end else begin
          n_c = 2'd2;
        end
      end
      default: n_c = 2'd0;
    endcase

    n_tot = {1'b0, n_a} + {1'b0, n_c};

    if (n_a != 2'd0) begin
      slot[0] = a0;
      slot[1] = a1;
      slot[2] = c0;
      slot[3] = c1;
    end else begin
      slot[0] = c0;
      slot[1] = c1;
      slot[2] = c0;
      slot[3] = c1;
    end
  end

  assign out_load = !out_tvalid_r || out_tready;
  assign emit     = run_valid_r && out_load;
  assign is_last  = ({1'b0, idx_r} + 3'd1) == n_tot;
  assign can_take = !run_valid_r || (emit && is_last);

  always_comb begin
    run_valid_nxt = run_valid_r;
    idx_nxt       = idx_r;
    if (emit) begin
      idx_nxt = idx_r + 1'b1;
      if (is_last) begin
        run_valid_nxt = 1'b0;
      end
    end
    if (load) begin
      run_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end
    out_tvalid_nxt = out_load ? run_valid_r : out_tvalid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_valid_r  <= 1'b0;
      idx_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      run_valid_r  <= run_valid_nxt;
      idx_r        <= idx_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      desc_r <= desc;
    end
    if (out_load) begin
      out_res_r  <= slot[idx_r];
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_res_r.value;
  assign out_tuser  = out_res_r.valid;
  assign out_tlast  = out_last_r;

endmodule

/* src/big5_utf16_table_codec_core.sv */
// Top level of the Big5 / UTF-16 table codec: input decisions, held state and wiring.
`timescale 1ns / 1ps

// Converts between Big5 byte strings and UTF-16 code units through two lookup
// memories. Each input item carries an action in in_tuser: load a table entry,
// decode a Big5 byte, encode a UTF-16 unit, or none; in_tlast ends a string.
// Loads give no output items. A decode or encode item gives zero to four
// output items; out_tlast marks the last one caused by that input item and
// out_tuser flags whether the conversion behind it was valid.
// The table read and the run descriptor are registered at acceptance; the
// first output item of an input item then moves into the output register as
// soon as that register can take it. An input item is taken while the result
// sequencer is empty, or in the cycle in which the previous one hands its
// last output item to the output register; loads and items that only update
// held state do not occupy the sequencer. After reset a clearing sweep writes
// every entry of both memories, one per cycle, and in_tready stays low until
// the sweep ends. A stalled out_tready holds the output item in its register;
// the next input item is still accepted while the sequencer has room, then
// in_tready drops until the output drains.

module big5_utf16_table_codec_core
  import b5u_pkg::*;
#(
  parameter int unsigned BIG5_CODES = BIG5_CODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // in_value[15:0], map_unicode[31:16], map_valid[32], zero pad
  input  logic [1:0]  in_tuser,   // action
  input  logic        in_tlast,   // end_of_string
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // out_value
  output logic [0:0]  out_tuser,  // out_valid
  output logic        out_tlast   // last_of_run
);

  localparam int unsigned FWD_AW     = $clog2(BIG5_CODES);
  localparam int unsigned BIG5_OFFSET = UNICODE_UNITS - BIG5_CODES;

  logic [15:0] in_value, map_unicode;
  logic        map_valid, eos;
  action_t     action;

  logic        lead_pending_r, lead_pending_nxt;
  logic [7:0]  held_lead_r, held_lead_nxt;
  logic        sur_pending_r, sur_pending_nxt;
  logic [15:0] held_sur_r, held_sur_nxt;

  logic        accept, tbl_ready, can_take;
  tbl_ctl_t    tbl_ctl;
  run_desc_t   desc;
  logic        has_results;

  logic [15:0]       dec_code;
  logic [16:0]       dec_sub, load_sub;
  logic              dec_in_range, load_in_range;
  logic [UNIT_W:0]   fwd_rdata;
  logic [UNIT_W-1:0] rev_rdata_a, rev_rdata_b;
  logic              is_lo_sur, is_hi_sur;

  assign in_value    = in_tdata[15:0];
  assign map_unicode = in_tdata[31:16];
  assign map_valid   = in_tdata[32];
  assign eos         = in_tlast;
  assign action      = action_t'(in_tuser);

  assign in_tready = tbl_ready && can_take;
  assign accept    = in_tvalid && in_tready;

  assign dec_code      = {held_lead_r, in_value[7:0]};
  assign dec_sub       = {1'b0, dec_code} - 17'(BIG5_OFFSET);
  assign dec_in_range  = {1'b0, dec_code} >= 17'(BIG5_OFFSET);
  assign load_sub      = {1'b0, in_value} - 17'(BIG5_OFFSET);
  assign load_in_range = {1'b0, in_value} >= 17'(BIG5_OFFSET);

  assign is_lo_sur = (in_value >= LO_SUR_MIN) && (in_value <= LO_SUR_MAX);
  assign is_hi_sur = (in_value >= HI_SUR_MIN) && (in_value <= HI_SUR_MAX);

  always_comb begin
    lead_pending_nxt  = lead_pending_r;
    held_lead_nxt     = held_lead_r;
    sur_pending_nxt   = sur_pending_r;
    held_sur_nxt      = held_sur_r;
    desc.pair         = PA_NONE;
    desc.cur          = CK_NONE;
    desc.lit          = in_value;
    desc.fwd_in_range = dec_in_range;
    tbl_ctl.rd_en     = accept;
    tbl_ctl.fwd_we    = 1'b0;
    tbl_ctl.rev_we    = 1'b0;

    case (action)
      ACT_LOAD: begin
        tbl_ctl.fwd_we = accept && load_in_range;
        tbl_ctl.rev_we = accept && load_in_range && map_valid;
      end
      ACT_DECODE: begin
        desc.lit = {8'h00, in_value[7:0]};
        if (lead_pending_r) begin
          lead_pending_nxt = 1'b0;
          desc.cur         = CK_FWD;
        end else if ({8'h00, in_value[7:0]} <= ASCII_MAX) begin
          desc.cur = CK_LIT;
        end else if (eos) begin
          desc.cur = CK_SPACE;
        end else begin
          lead_pending_nxt = 1'b1;
          held_lead_nxt    = in_value[7:0];
        end
      end
      ACT_ENCODE: begin
        if (sur_pending_r && is_lo_sur) begin
          // A complete surrogate pair has no Big5 form.
          sur_pending_nxt = 1'b0;
          desc.pair       = PA_SPACES;
        end else begin
          if (sur_pending_r) begin
            sur_pending_nxt = 1'b0;
            desc.pair       = PA_LOOKUP;
          end
          if (in_value <= ASCII_MAX) begin
            desc.cur = CK_LIT;
          end else if (is_hi_sur && !eos) begin
            sur_pending_nxt = 1'b1;
            held_sur_nxt    = in_value;
          end else begin
            desc.cur = CK_REV;
          end
        end
      end
      default: begin
        tbl_ctl.rd_en = accept;
      end
    endcase

    if (!accept) begin
      lead_pending_nxt = lead_pending_r;
      held_lead_nxt    = held_lead_r;
      sur_pending_nxt  = sur_pending_r;
      held_sur_nxt     = held_sur_r;
    end
  end

  assign has_results = (desc.pair != PA_NONE) || (desc.cur != CK_NONE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_pending_r <= 1'b0;
      held_lead_r    <= '0;
      sur_pending_r  <= 1'b0;
      held_sur_r     <= '0;
    end else begin
      lead_pending_r <= lead_pending_nxt;
      held_lead_r    <= held_lead_nxt;
      sur_pending_r  <= sur_pending_nxt;
      held_sur_r     <= held_sur_nxt;
    end
  end

  b5u_tables #(
    .BIG5_CODES(BIG5_CODES)
  ) u_tables (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (tbl_ctl),
    .fwd_raddr  (dec_sub[FWD_AW-1:0]),
    .fwd_waddr  (load_sub[FWD_AW-1:0]),
    .fwd_wdata  (map_valid ? {1'b1, map_unicode} : {(UNIT_W+1){1'b0}}),
    .rev_raddr_a(held_sur_r),
    .rev_raddr_b(in_value),
    .rev_waddr  (map_unicode),
    .rev_wdata  (in_value),
    .fwd_rdata  (fwd_rdata),
    .rev_rdata_a(rev_rdata_a),
    .rev_rdata_b(rev_rdata_b),
    .ready      (tbl_ready)
  );

  b5u_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && has_results),
    .desc       (desc),
    .fwd_rdata  (fwd_rdata),
    .rev_rdata_a(rev_rdata_a),
    .rev_rdata_b(rev_rdata_b),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // A decoded trail byte always consumes the held lead byte.
  a_lead_consumed: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && action == ACT_DECODE && lead_pending_r) |=> !lead_pending_r)
    else $error("lead byte still pending after its trail byte");

  // Only a non-ASCII byte can be held as a lead byte.
  a_lead_non_ascii: assert property (@(posedge clk) disable iff (!rst_n)
    lead_pending_r |-> held_lead_r[7])
    else $error("held lead byte is ASCII");

  // A held unit is always a high surrogate.
  a_held_high_sur: assert property (@(posedge clk) disable iff (!rst_n)
    sur_pending_r |-> (held_sur_r >= HI_SUR_MIN && held_sur_r <= HI_SUR_MAX))
    else $error("held unit is not a high surrogate");

  // No item is taken while the clearing sweep owns the memories.
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !tbl_ready |-> !in_tready)
    else $error("input taken during clearing sweep");

endmodule
